[rtl/cosine_interp_graph_scaler_macros.svh]
// assertion macros shared by the scaler rtl
// no dependencies; included by modules that carry checks
`ifndef COSINE_INTERP_GRAPH_SCALER_MACROS_SVH
`define COSINE_INTERP_GRAPH_SCALER_MACROS_SVH

// same-cycle implication
`define CIGS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cigs implication check failed");

// next-cycle implication
`define CIGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cigs next-cycle check failed");

`endif

[rtl/cigs_pkg.sv]
// types, widths and the cosine weight function of the graph scaler
// no dependencies; imported by every rtl module of the block
`default_nettype none

package cigs_pkg;

   localparam int COLUMN_W   = 10;
   localparam int HEIGHT_W   = 12;
   localparam int SAMPLE_W   = 16;
   localparam int INDEX_W    = 7;
   localparam int STEP_W     = 24;
   localparam int GH_W       = 10;
   localparam int FS_W       = 16;
   localparam int USED_W     = 8;
   localparam int CSR_DATA_W = 24;
   localparam int FRAC_W     = 16;
   localparam int POS_W      = COLUMN_W + STEP_W;
   localparam int POS_INT_W  = POS_W - FRAC_W;
   localparam int WEIGHT_W   = 17;
   localparam int BLEND_W    = 32;
   localparam int SCALED_W   = BLEND_W + GH_W;
   localparam int DIVIDEND_W = SCALED_W - FRAC_W;
   localparam int QUO_W      = HEIGHT_W;
   localparam int DIV_CMP_W  = FS_W + QUO_W;

   localparam int FRONT_STAGES = 3;
   localparam int STORE_STAGES = 1;
   localparam int BLEND_STAGES = 3;
   localparam int DIV_STEPS    = 2;
   localparam int DIV_STAGES   = QUO_W / DIV_STEPS;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 12'hFFF;

   localparam logic [STEP_W-1:0] STEP_FACTOR_RST  = 24'd65536;
   localparam logic [GH_W-1:0]   PLOT_HEIGHT_RST  = 10'd64;
   localparam logic [FS_W-1:0]   FULL_SCALE_RST   = 16'd300;
   localparam logic [USED_W-1:0] SAMPLES_USED_RST = 8'd64;

   localparam logic [63:0] PI_Q28  = 64'd843314857;
   localparam logic [63:0] ONE_Q28 = 64'd268435456;
   localparam int TAYLOR_TERMS = 12;
   localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
      64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
   };

   typedef enum logic [0:0] {
      FUNC_LOAD  = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      CSR_STEP_FACTOR  = 2'd0,
      CSR_PLOT_HEIGHT  = 2'd1,
      CSR_FULL_SCALE   = 2'd2,
      CSR_SAMPLES_USED = 2'd3
   } csr_index_type;

   typedef struct packed {
      func_type              func;
      logic [INDEX_W-1:0]    sample_index;
      logic [SAMPLE_W-1:0]   sample_value;
      logic [COLUMN_W-1:0]   pixel_column;
   } req_type;

   typedef struct packed {
      logic [COLUMN_W-1:0]   column;
      logic [HEIGHT_W-1:0]   height;
   } rsp_type;

   typedef struct packed {
      logic [STEP_W-1:0]     step_factor;
      logic [GH_W-1:0]       plot_height;
      logic [FS_W-1:0]       full_scale;
      logic [USED_W-1:0]     samples_used;
   } cfg_type;

   // (1 - cos(pi * k / 2^bits)) / 2 in q0.16, integer taylor series in q4.28
   function automatic logic [WEIGHT_W-1:0] cos_weight(input int unsigned k,
                                                      input int unsigned bits);
      logic [63:0]        t;
      logic [63:0]        t2;
      logic [63:0]        term;
      logic signed [63:0] c;
      logic signed [63:0] w;
      int unsigned        n;
      t    = (PI_Q28 * 64'(k)) >> bits;
      t2   = (t * t) >> 28;
      term = ONE_Q28;
      c    = $signed(ONE_Q28);
      for (n = 1; n <= TAYLOR_TERMS; n++) begin
         term = ((term * t2) >> 28) / TAYLOR_DIV[n - 1];
         if (n[0]) begin
            c = c - $signed(term);
         end else begin
            c = c + $signed(term);
         end
      end
      w = $signed(ONE_Q28) - c + 64'sd4096;
      if (w < 64'sd0) begin
         w = 64'sd0;
      end
      w = w >>> 13;
      if (w > $signed(64'(WEIGHT_ONE))) begin
         w = $signed(64'(WEIGHT_ONE));
      end
      return WEIGHT_W'(w);
   endfunction

endpackage

`default_nettype wire

[rtl/cigs_front.sv]
// front stages: request capture, position multiply, neighbor index and fraction
// depends on cigs_pkg
`default_nettype none

module cigs_front #(
   parameter int SAMPLES           = 128,
   parameter int WEIGHT_TABLE_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  cigs_pkg::req_type              in_req,
   input  cigs_pkg::cfg_type              cfg,
   output logic                           out_valid,
   output logic                           out_load,
   output logic [cigs_pkg::INDEX_W-1:0]   out_index,
   output logic [cigs_pkg::SAMPLE_W-1:0]  out_value,
   output logic [cigs_pkg::COLUMN_W-1:0]  out_column,
   output logic [$clog2(SAMPLES)-1:0]     out_left,
   output logic [$clog2(SAMPLES)-1:0]     out_right,
   output logic [WEIGHT_TABLE_BITS-1:0]   out_k
);
   import cigs_pkg::*;

   localparam int IDX_W = $clog2(SAMPLES);

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   req_type               s1_req_ff;
   req_type               s1_req_in;

   logic                  s2_valid_ff;
   logic                  s2_valid_in;
   logic                  s2_load_ff;
   logic                  s2_load_in;
   logic [INDEX_W-1:0]    s2_index_ff;
   logic [SAMPLE_W-1:0]   s2_value_ff;
   logic [COLUMN_W-1:0]   s2_column_ff;
   logic [POS_W-1:0]      s2_pos_ff;
   logic [POS_W-1:0]      s2_pos_in;

   logic                  s3_valid_ff;
   logic                  s3_load_ff;
   logic [INDEX_W-1:0]    s3_index_ff;
   logic [SAMPLE_W-1:0]   s3_value_ff;
   logic [COLUMN_W-1:0]   s3_column_ff;
   logic [IDX_W-1:0]      s3_left_ff;
   logic [IDX_W-1:0]      s3_left_in;
   logic [IDX_W-1:0]      s3_right_ff;
   logic [IDX_W-1:0]      s3_right_in;
   logic [WEIGHT_TABLE_BITS-1:0] s3_k_ff;
   logic [WEIGHT_TABLE_BITS-1:0] s3_k_in;

   logic [POS_INT_W-1:0]  used;
   logic [POS_INT_W-1:0]  last;
   logic [POS_INT_W-1:0]  left_full;

   // stage 1: request capture
   assign s1_valid_in = in_valid;
   assign s1_req_in   = in_req;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_req_ff <= s1_req_in;
   end

   // stage 2: sample position in q18.16
   assign s2_valid_in = s1_valid_ff;
   assign s2_load_in  = (s1_req_ff.func == FUNC_LOAD);
   assign s2_pos_in   = POS_W'(s1_req_ff.pixel_column) * POS_W'(cfg.step_factor);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      s2_load_ff   <= s2_load_in;
      s2_index_ff  <= s1_req_ff.sample_index;
      s2_value_ff  <= s1_req_ff.sample_value;
      s2_column_ff <= s1_req_ff.pixel_column;
      s2_pos_ff    <= s2_pos_in;
   end

   // stage 3: clamp neighbors to the last used sample
   always_comb begin
      used = POS_INT_W'(cfg.samples_used);
      if (used < POS_INT_W'(2)) begin
         used = POS_INT_W'(2);
      end else if (used > POS_INT_W'(SAMPLES)) begin
         used = POS_INT_W'(SAMPLES);
      end
      last      = used - POS_INT_W'(1);
      left_full = s2_pos_ff[POS_W-1:FRAC_W];
      if (left_full >= last) begin
         s3_left_in  = last[IDX_W-1:0];
         s3_right_in = last[IDX_W-1:0];
      end else begin
         s3_left_in  = left_full[IDX_W-1:0];
         s3_right_in = left_full[IDX_W-1:0] + IDX_W'(1);
      end
      s3_k_in = s2_pos_ff[FRAC_W-1 -: WEIGHT_TABLE_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_load_ff   <= s2_load_ff;
      s3_index_ff  <= s2_index_ff;
      s3_value_ff  <= s2_value_ff;
      s3_column_ff <= s2_column_ff;
      s3_left_ff   <= s3_left_in;
      s3_right_ff  <= s3_right_in;
      s3_k_ff      <= s3_k_in;
   end

   assign out_valid  = s3_valid_ff;
   assign out_load   = s3_load_ff;
   assign out_index  = s3_index_ff;
   assign out_value  = s3_value_ff;
   assign out_column = s3_column_ff;
   assign out_left   = s3_left_ff;
   assign out_right  = s3_right_ff;
   assign out_k      = s3_k_ff;

endmodule

`default_nettype wire

[rtl/cigs_store.sv]
// sample memory with one write and two read ports, plus the cosine weight rom
// depends on cigs_pkg and cosine_interp_graph_scaler_macros.svh
`default_nettype none
`include "cosine_interp_graph_scaler_macros.svh"

module cigs_store #(
   parameter int SAMPLES           = 128,
   parameter int WEIGHT_TABLE_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic                           in_load,
   input  logic [cigs_pkg::INDEX_W-1:0]   in_index,
   input  logic [cigs_pkg::SAMPLE_W-1:0]  in_value,
   input  logic [cigs_pkg::COLUMN_W-1:0]  in_column,
   input  logic [$clog2(SAMPLES)-1:0]     in_left,
   input  logic [$clog2(SAMPLES)-1:0]     in_right,
   input  logic [WEIGHT_TABLE_BITS-1:0]   in_k,
   output logic                           out_valid,
   output logic [cigs_pkg::COLUMN_W-1:0]  out_column,
   output logic [cigs_pkg::SAMPLE_W-1:0]  out_left,
   output logic [cigs_pkg::SAMPLE_W-1:0]  out_right,
   output logic [cigs_pkg::WEIGHT_W-1:0]  out_weight
);
   import cigs_pkg::*;

   localparam int IDX_W          = $clog2(SAMPLES);
   localparam int WEIGHT_ENTRIES = 2 ** WEIGHT_TABLE_BITS;

   logic [SAMPLE_W-1:0] sample_mem [SAMPLES];
   logic [WEIGHT_W-1:0] weight_rom [WEIGHT_ENTRIES];

   logic                out_valid_ff;
   logic                out_valid_in;
   logic [COLUMN_W-1:0] column_ff;
   logic [SAMPLE_W-1:0] left_ff;
   logic [SAMPLE_W-1:0] right_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;

   for (genvar g = 0; g < WEIGHT_ENTRIES; g++) begin : g_rom
      localparam logic [WEIGHT_W-1:0] WEIGHT = cos_weight(g, WEIGHT_TABLE_BITS);
      assign weight_rom[g] = WEIGHT;
   end

   // loads beyond the store are dropped
   assign wr_en        = in_valid && in_load && (32'(in_index) < SAMPLES);
   assign wr_addr      = IDX_W'(in_index);
   assign out_valid_in = in_valid && !in_load;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_mem[wr_addr] <= in_value;
      end
      left_ff  <= sample_mem[in_left];
      right_ff <= sample_mem[in_right];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      column_ff <= in_column;
      weight_ff <= weight_rom[in_k];
   end

   assign out_valid  = out_valid_ff;
   assign out_column = column_ff;
   assign out_left   = left_ff;
   assign out_right  = right_ff;
   assign out_weight = weight_ff;

   `CIGS_ASSERT_NEXT(a_store_query_flows, clock, reset, in_valid && !in_load, out_valid_ff)
   `CIGS_ASSERT_NEXT(a_store_load_absorbed, clock, reset, in_valid && in_load, !out_valid_ff)

endmodule

`default_nettype wire

[rtl/cigs_blend.sv]
// blend stages: weighted products, sum, scale by plot height
// depends on cigs_pkg
`default_nettype none

module cigs_blend (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [cigs_pkg::COLUMN_W-1:0]  in_column,
   input  logic [cigs_pkg::SAMPLE_W-1:0]  in_left,
   input  logic [cigs_pkg::SAMPLE_W-1:0]  in_right,
   input  logic [cigs_pkg::WEIGHT_W-1:0]  in_weight,
   input  cigs_pkg::cfg_type              cfg,
   output logic                           out_valid,
   output logic [cigs_pkg::COLUMN_W-1:0]  out_column,
   output logic [cigs_pkg::SCALED_W-1:0]  out_scaled
);
   import cigs_pkg::*;

   logic                p1_valid_ff;
   logic [COLUMN_W-1:0] p1_column_ff;
   logic [BLEND_W-1:0]  p1_prod_l_ff;
   logic [BLEND_W-1:0]  p1_prod_l_in;
   logic [BLEND_W-1:0]  p1_prod_r_ff;
   logic [BLEND_W-1:0]  p1_prod_r_in;
   logic [WEIGHT_W-1:0] inv_weight;

   logic                p2_valid_ff;
   logic [COLUMN_W-1:0] p2_column_ff;
   logic [BLEND_W-1:0]  p2_sum_ff;
   logic [BLEND_W-1:0]  p2_sum_in;

   logic                p3_valid_ff;
   logic [COLUMN_W-1:0] p3_column_ff;
   logic [SCALED_W-1:0] p3_scaled_ff;
   logic [SCALED_W-1:0] p3_scaled_in;

   // products of the two neighbors, each below 2^32
   assign inv_weight   = WEIGHT_ONE - in_weight;
   assign p1_prod_l_in = BLEND_W'(inv_weight) * BLEND_W'(in_left);
   assign p1_prod_r_in = BLEND_W'(in_weight) * BLEND_W'(in_right);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= in_valid;
      end
      p1_column_ff <= in_column;
      p1_prod_l_ff <= p1_prod_l_in;
      p1_prod_r_ff <= p1_prod_r_in;
   end

   assign p2_sum_in = p1_prod_l_ff + p1_prod_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
      p2_column_ff <= p1_column_ff;
      p2_sum_ff    <= p2_sum_in;
   end

   assign p3_scaled_in = SCALED_W'(p2_sum_ff) * SCALED_W'(cfg.plot_height);

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff;
      end
      p3_column_ff <= p2_column_ff;
      p3_scaled_ff <= p3_scaled_in;
   end

   assign out_valid  = p3_valid_ff;
   assign out_column = p3_column_ff;
   assign out_scaled = p3_scaled_ff;

endmodule

`default_nettype wire

[rtl/cigs_div.sv]
// pipelined restoring divider by full scale, two quotient bits per stage, saturating
// depends on cigs_pkg and cosine_interp_graph_scaler_macros.svh
`default_nettype none
`include "cosine_interp_graph_scaler_macros.svh"

module cigs_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [cigs_pkg::COLUMN_W-1:0]  in_column,
   input  logic [cigs_pkg::SCALED_W-1:0]  in_scaled,
   input  cigs_pkg::cfg_type              cfg,
   output logic                           out_valid,
   output cigs_pkg::rsp_type              out_rsp
);
   import cigs_pkg::*;

   localparam int LAST = DIV_STAGES - 1;

   logic                  vld_ff [DIV_STAGES];
   logic                  sat_ff [DIV_STAGES];
   logic [COLUMN_W-1:0]   col_ff [DIV_STAGES];
   logic [DIVIDEND_W-1:0] rem_ff [DIV_STAGES];
   logic [QUO_W-1:0]      quo_ff [DIV_STAGES];
   logic [DIVIDEND_W-1:0] dividend;

   function automatic logic [DIVIDEND_W:0] div_step(input logic [DIVIDEND_W-1:0] rem,
                                                    input logic [FS_W-1:0] divisor,
                                                    input int unsigned sh);
      logic [DIV_CMP_W-1:0] shifted;
      logic [DIV_CMP_W-1:0] wide_rem;
      shifted  = DIV_CMP_W'(divisor) << sh;
      wide_rem = DIV_CMP_W'(rem);
      if (wide_rem >= shifted) begin
         return {1'b1, DIVIDEND_W'(wide_rem - shifted)};
      end else begin
         return {1'b0, rem};
      end
   endfunction

   // dropping the low 16 bits first gives the same floor
   assign dividend = in_scaled[SCALED_W-1 -: DIVIDEND_W];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      localparam int HI = QUO_W - 1 - DIV_STEPS * s;

      logic                  prev_valid;
      logic                  prev_sat;
      logic [COLUMN_W-1:0]   prev_col;
      logic [DIVIDEND_W-1:0] prev_rem;
      logic [QUO_W-1:0]      prev_quo;
      logic [DIVIDEND_W:0]   step_hi;
      logic [DIVIDEND_W:0]   step_lo;
      logic [QUO_W-1:0]      quo_in;

      if (s == 0) begin : g_head
         // quotient of 4096 or more, or zero full scale, saturates
         assign prev_valid = in_valid;
         assign prev_sat   = DIV_CMP_W'(dividend) >= (DIV_CMP_W'(cfg.full_scale) << QUO_W);
         assign prev_col   = in_column;
         assign prev_rem   = dividend;
         assign prev_quo   = '0;
      end else begin : g_body
         assign prev_valid = vld_ff[s-1];
         assign prev_sat   = sat_ff[s-1];
         assign prev_col   = col_ff[s-1];
         assign prev_rem   = rem_ff[s-1];
         assign prev_quo   = quo_ff[s-1];
      end

      assign step_hi = div_step(prev_rem, cfg.full_scale, HI);
      assign step_lo = div_step(step_hi[DIVIDEND_W-1:0], cfg.full_scale, HI - 1);

      always_comb begin
         quo_in         = prev_quo;
         quo_in[HI]     = step_hi[DIVIDEND_W];
         quo_in[HI - 1] = step_lo[DIVIDEND_W];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= prev_valid;
         end
         sat_ff[s] <= prev_sat;
         col_ff[s] <= prev_col;
         rem_ff[s] <= step_lo[DIVIDEND_W-1:0];
         quo_ff[s] <= quo_in;
      end
   end

   assign out_valid      = vld_ff[LAST];
   assign out_rsp.column = col_ff[LAST];
   assign out_rsp.height = sat_ff[LAST] ? HEIGHT_MAX : quo_ff[LAST];

   `CIGS_ASSERT_IMPLY(a_div_remainder_bound, clock, reset, vld_ff[LAST] && !sat_ff[LAST], DIV_CMP_W'(rem_ff[LAST]) < DIV_CMP_W'(cfg.full_scale))

endmodule

`default_nettype wire

[rtl/cosine_interp_graph_scaler.sv]
// top level of the cosine interpolating graph scaler: config registers and pipeline
// depends on cigs_pkg, cigs_front, cigs_store, cigs_blend, cigs_div and the macros header
//
//   port group   direction  handshake              payload
//   req_         in         start, busy            req_data (load or query request)
//   rsp_         out        rsp_strobe             rsp_data (column, height)
//   csr_         in         csr_valid, csr_ready   csr_index, csr_wdata
//
// one request accepted per cycle; busy stays low, so requests never wait
// a query passes through three front stages, the memory read, three blend stages
// and a six-stage divider by full scale
// loads give no result and land in the memory at the read stage, in request order
// synchronous reset clears the pipeline valids and the config registers;
// the sample memory is not cleared and has no clearing pass
// the receiver cannot stall; the strobe marks each result for one cycle
`default_nettype none
`include "cosine_interp_graph_scaler_macros.svh"

module cosine_interp_graph_scaler #(
   parameter int SAMPLES           = 128,
   parameter int WEIGHT_TABLE_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  cigs_pkg::req_type                req_data,
   output logic                             rsp_strobe,
   output cigs_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  cigs_pkg::csr_index_type          csr_index,
   input  logic [cigs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cigs_pkg::*;

   localparam int IDX_W        = $clog2(SAMPLES);
   localparam int PIPE_LATENCY = FRONT_STAGES + STORE_STAGES + BLEND_STAGES + DIV_STAGES;

   logic [STEP_W-1:0] step_factor_ff;
   logic [GH_W-1:0]   plot_height_ff;
   logic [FS_W-1:0]   full_scale_ff;
   logic [USED_W-1:0] samples_used_ff;
   cfg_type           cfg;
   logic              accept;

   logic                 fr_valid;
   logic                 fr_load;
   logic [INDEX_W-1:0]   fr_index;
   logic [SAMPLE_W-1:0]  fr_value;
   logic [COLUMN_W-1:0]  fr_column;
   logic [IDX_W-1:0]     fr_left;
   logic [IDX_W-1:0]     fr_right;
   logic [WEIGHT_TABLE_BITS-1:0] fr_k;

   logic                 st_valid;
   logic [COLUMN_W-1:0]  st_column;
   logic [SAMPLE_W-1:0]  st_left;
   logic [SAMPLE_W-1:0]  st_right;
   logic [WEIGHT_W-1:0]  st_weight;

   logic                 bl_valid;
   logic [COLUMN_W-1:0]  bl_column;
   logic [SCALED_W-1:0]  bl_scaled;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_factor_ff  <= STEP_FACTOR_RST;
         plot_height_ff  <= PLOT_HEIGHT_RST;
         full_scale_ff   <= FULL_SCALE_RST;
         samples_used_ff <= SAMPLES_USED_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STEP_FACTOR:  step_factor_ff  <= csr_wdata;
            CSR_PLOT_HEIGHT:  plot_height_ff  <= csr_wdata[GH_W-1:0];
            CSR_FULL_SCALE:   full_scale_ff   <= csr_wdata[FS_W-1:0];
            CSR_SAMPLES_USED: samples_used_ff <= csr_wdata[USED_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.step_factor  = step_factor_ff;
      cfg.plot_height  = plot_height_ff;
      cfg.full_scale   = full_scale_ff;
      cfg.samples_used = samples_used_ff;
   end

   cigs_front #(
      .SAMPLES           (SAMPLES),
      .WEIGHT_TABLE_BITS (WEIGHT_TABLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_req     (req_data),
      .cfg        (cfg),
      .out_valid  (fr_valid),
      .out_load   (fr_load),
      .out_index  (fr_index),
      .out_value  (fr_value),
      .out_column (fr_column),
      .out_left   (fr_left),
      .out_right  (fr_right),
      .out_k      (fr_k)
   );

   cigs_store #(
      .SAMPLES           (SAMPLES),
      .WEIGHT_TABLE_BITS (WEIGHT_TABLE_BITS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (fr_valid),
      .in_load    (fr_load),
      .in_index   (fr_index),
      .in_value   (fr_value),
      .in_column  (fr_column),
      .in_left    (fr_left),
      .in_right   (fr_right),
      .in_k       (fr_k),
      .out_valid  (st_valid),
      .out_column (st_column),
      .out_left   (st_left),
      .out_right  (st_right),
      .out_weight (st_weight)
   );

   cigs_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (st_valid),
      .in_column  (st_column),
      .in_left    (st_left),
      .in_right   (st_right),
      .in_weight  (st_weight),
      .cfg        (cfg),
      .out_valid  (bl_valid),
      .out_column (bl_column),
      .out_scaled (bl_scaled)
   );

   cigs_div u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (bl_valid),
      .in_column  (bl_column),
      .in_scaled  (bl_scaled),
      .cfg        (cfg),
      .out_valid  (rsp_strobe),
      .out_rsp    (rsp_data)
   );

   `CIGS_ASSERT_IMPLY(a_rsp_follows_query, clock, reset, rsp_strobe, $past(accept && (req_data.func == FUNC_QUERY), PIPE_LATENCY) && (rsp_data.column == $past(req_data.pixel_column, PIPE_LATENCY)))

endmodule

`default_nettype wire

[tb/tb_cosine_interp_graph_scaler.sv]
// self-checking testbench for cosine_interp_graph_scaler: loads samples, runs column
// queries under many register settings and compares every height with its own predictor
// depends on cigs_pkg and the rtl of the block
`default_nettype none

module tb_cosine_interp_graph_scaler;
   import cigs_pkg::*;

   localparam int STORE_DEPTH    = 128;
   localparam int DRAIN_CYCLES   = 16;
   localparam int STALL_LIMIT    = 2000;
   localparam int PHASE_REQUESTS = 37;
   localparam int RANDOM_PHASES  = 6;

   class height_scoreboard;
      cfg_type             cfg;
      logic [SAMPLE_W-1:0] samples [STORE_DEPTH];
      logic [16:0]         cos_weights [256];
      rsp_type             expected_heights [$];
      int                  errors;

      function new();
         cfg.step_factor  = STEP_FACTOR_RST;
         cfg.plot_height  = PLOT_HEIGHT_RST;
         cfg.full_scale   = FULL_SCALE_RST;
         cfg.samples_used = SAMPLES_USED_RST;
         errors = 0;
         for (int k = 0; k < 256; k++) begin
            cos_weights[k] = weight_for(k);
         end
      endfunction

      // (1 - cos(pi * k / 256)) / 2 in q0.16 from a fixed-point taylor series
      function logic [16:0] weight_for(int unsigned k);
         longint unsigned angle;
         longint unsigned angle_sq;
         longint unsigned term;
         longint          c;
         longint          w;
         angle    = (64'd843314857 * 64'(k)) >> 8;
         angle_sq = (angle * angle) >> 28;
         term     = 64'd268435456;
         c        = 64'sd268435456;
         for (int n = 1; n <= 12; n++) begin
            term = ((term * angle_sq) >> 28) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
               c = c - longint'(term);
            end else begin
               c = c + longint'(term);
            end
         end
         w = 64'sd268435456 - c + 64'sd4096;
         if (w < 0) begin
            w = 0;
         end
         w = w >>> 13;
         if (w > 65536) begin
            w = 65536;
         end
         return w[16:0];
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_STEP_FACTOR:  cfg.step_factor  = data[STEP_W-1:0];
            CSR_PLOT_HEIGHT:  cfg.plot_height  = data[GH_W-1:0];
            CSR_FULL_SCALE:   cfg.full_scale   = data[FS_W-1:0];
            CSR_SAMPLES_USED: cfg.samples_used = data[USED_W-1:0];
            default: ;
         endcase
      endfunction

      function rsp_type predict_height(logic [COLUMN_W-1:0] column);
         rsp_type         r;
         longint unsigned last;
         longint unsigned pos;
         longint unsigned left;
         longint unsigned right;
         longint unsigned w;
         longint unsigned blend;
         longint unsigned q;
         if (cfg.samples_used < 2) begin
            last = 1;
         end else if (cfg.samples_used > STORE_DEPTH) begin
            last = STORE_DEPTH - 1;
         end else begin
            last = 64'(cfg.samples_used) - 1;
         end
         pos  = 64'(column) * 64'(cfg.step_factor);
         left = pos >> 16;
         w    = 64'(cos_weights[pos[15:8]]);
         if (left >= last) begin
            left  = last;
            right = last;
         end else begin
            right = left + 1;
         end
         blend = (64'd65536 - w) * 64'(samples[left]) + w * 64'(samples[right]);
         r.column = column;
         if (cfg.full_scale == 0) begin
            r.height = HEIGHT_MAX;
         end else begin
            q = (blend * 64'(cfg.plot_height)) / (64'(cfg.full_scale) << 16);
            r.height = (q > 64'd4095) ? HEIGHT_MAX : q[HEIGHT_W-1:0];
         end
         return r;
      endfunction

      function void note_request(req_type r);
         if (r.func == FUNC_LOAD) begin
            samples[r.sample_index] = r.sample_value;
         end else begin
            expected_heights.push_back(predict_height(r.pixel_column));
         end
      endfunction

      task report_mismatch(string what, int got, int want);
         errors++;
         if (errors <= 100) begin
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
         end
      endtask

      task check_height(rsp_type got);
         rsp_type want;
         if (expected_heights.size() == 0) begin
            report_mismatch("unexpected result, column", got.column, -1);
            return;
         end
         want = expected_heights.pop_front();
         if (got.column != want.column) begin
            report_mismatch("column", got.column, want.column);
         end
         if (got.height != want.height) begin
            report_mismatch("height", got.height, want.height);
         end
      endtask
   endclass

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    start     = 1'b0;
   logic                    busy;
   req_type                 req_data  = '0;
   logic                    rsp_strobe;
   rsp_type                 rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   csr_index_type           csr_index = CSR_STEP_FACTOR;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   int                      stall_cycles = 0;
   height_scoreboard        board;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cosine_interp_graph_scaler dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            board.check_height(rsp_data);
         end
         if (start && !busy) begin
            board.note_request(req_data);
         end
         if (csr_valid && csr_ready) begin
            board.write_reg(csr_index, csr_wdata);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy) || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_request(req_type r, int unsigned gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // loads give no result, so wait out the pipeline after the last height
   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (board.expected_heights.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(cfg_type s);
      drain_pipeline();
      write_csr(CSR_STEP_FACTOR,  CSR_DATA_W'(s.step_factor));
      write_csr(CSR_PLOT_HEIGHT,  CSR_DATA_W'(s.plot_height));
      write_csr(CSR_FULL_SCALE,   CSR_DATA_W'(s.full_scale));
      write_csr(CSR_SAMPLES_USED, CSR_DATA_W'(s.samples_used));
      csr_valid <= 1'b0;
   endtask

   function automatic req_type random_request(bit is_query);
      req_type r;
      r.func         = is_query ? FUNC_QUERY : FUNC_LOAD;
      r.sample_index = INDEX_W'($urandom);
      r.sample_value = SAMPLE_W'($urandom);
      r.pixel_column = COLUMN_W'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         r.sample_value = $urandom_range(0, 1) ? '1 : '0;
      end
      if ($urandom_range(0, 9) == 0) begin
         r.pixel_column = $urandom_range(0, 1) ? '1 : '0;
      end
      return r;
   endfunction

   function automatic req_type query_for(logic [COLUMN_W-1:0] column);
      req_type r;
      r = random_request(1'b1);
      r.pixel_column = column;
      return r;
   endfunction

   function automatic cfg_type random_settings();
      cfg_type s;
      if ($urandom_range(0, 5) == 0) begin
         s.samples_used = USED_W'($urandom);
      end else begin
         s.samples_used = USED_W'($urandom_range(2, STORE_DEPTH));
      end
      // mostly steps that sweep the used samples across the 1024 columns
      if ($urandom_range(0, 4) == 0) begin
         s.step_factor = STEP_W'($urandom);
      end else begin
         s.step_factor = STEP_W'($urandom_range(0, (int'(s.samples_used) + 1) * 130));
      end
      s.plot_height = GH_W'($urandom_range(1, 1023));
      if ($urandom_range(0, 2) == 0) begin
         s.full_scale = FS_W'($urandom_range(1, 1023));
      end else begin
         s.full_scale = FS_W'($urandom_range(1000, 65535));
      end
      return s;
   endfunction

   task automatic run_phase(int unsigned count);
      bit burst;
      burst = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < count; i++) begin
         send_request(random_request($urandom_range(0, 9) < 7),
                      burst ? 0 : $urandom_range(0, 3));
      end
   endtask

   initial begin
      cfg_type corner_settings [5];
      req_type r;
      board = new();
      corner_settings = '{
         '{24'h000000, 10'd0,    16'd0,     8'd0},
         '{24'hFFFFFF, 10'd1023, 16'd1,     8'd255},
         '{24'h000100, 10'd0,    16'd65535, 8'd1},
         '{24'h00C000, 10'd1023, 16'd65535, 8'd128},
         '{24'h020000, 10'd512,  16'd300,   8'd200}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole store so that no query reads an unwritten slot
      for (int i = 0; i < STORE_DEPTH; i++) begin
         r = random_request(1'b0);
         r.sample_index = INDEX_W'(i);
         if (i == 0) begin
            r.sample_value = '1;
         end else if (i == 1) begin
            r.sample_value = '0;
         end
         send_request(r, $urandom_range(0, 3));
      end

      // reset settings: first column, last column, left neighbour at and past the data end
      send_request(query_for(10'd0), 0);
      send_request(query_for(10'd1), 0);
      send_request(query_for(10'd62), 1);
      send_request(query_for(10'd63), 0);
      send_request(query_for(10'd64), 2);
      send_request(query_for(10'd1023), 0);
      r = random_request(1'b0);
      r.sample_index = 7'd63;
      r.sample_value = 16'hFFFF;
      send_request(r, 0);
      send_request(query_for(10'd62), 0);
      send_request(query_for(10'd63), 3);

      foreach (corner_settings[i]) begin
         apply_settings(corner_settings[i]);
         send_request(query_for(10'd0), 0);
         send_request(query_for(10'd1023), 0);
         run_phase(PHASE_REQUESTS);
      end
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         apply_settings(random_settings());
         run_phase(PHASE_REQUESTS);
      end

      drain_pipeline();
      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/cigs_pkg.sv
rtl/cigs_front.sv
rtl/cigs_store.sv
rtl/cigs_blend.sv
rtl/cigs_div.sv
rtl/cosine_interp_graph_scaler.sv
tb/tb_cosine_interp_graph_scaler.sv
